// File: design/sorted_list_insert_delete_unit_macros.svh
// Assertion macros used by the checker file of the sorted list unit
`ifndef SORTED_LIST_INSERT_DELETE_UNIT_MACROS_SVH
`define SORTED_LIST_INSERT_DELETE_UNIT_MACROS_SVH

// Check on every clock edge, skipped while reset is asserted
`define SLID_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check on every clock edge, reset included
`define SLID_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/slid_pkg.sv
// Types and codes shared by the sorted list unit
`timescale 1ns / 1ps
`default_nettype none

package slid_pkg;

	typedef enum logic {
		CMD_INSERT = 1'b0,
		CMD_DELETE = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_DONE      = 2'd0,
		STAT_NOT_FOUND = 2'd1,
		STAT_FULL      = 2'd2
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_EMIT = 1'b1
	} state_t;

	typedef enum logic [1:0] {
		CELL_HOLD   = 2'd0,
		CELL_INSERT = 2'd1,
		CELL_DELETE = 2'd2,
		CELL_ROTATE = 2'd3
	} cell_op_t;

	typedef struct packed {
		cmd_t               command;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic [4:0]         entry_count;
		logic [3:0]         position;
		logic signed [31:0] entry_value;
		logic               entry_valid;
		logic               last;
	} rsp_t;

	// Broadcast to every cell of the chain
	typedef struct packed {
		cell_op_t           op;
		logic signed [31:0] key;
	} cell_ctl_t;

endpackage

`default_nettype wire

// File: design/slid_cell.sv
// One cell of the sorted chain: holds one entry and trades it with its neighbors
`timescale 1ns / 1ps
`default_nettype none

module slid_cell (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire slid_pkg::cell_ctl_t ctl,
	input  wire logic signed [31:0]  head_val,
	input  wire logic signed [31:0]  left_val,
	input  wire logic                left_vld,
	input  wire logic                left_ins,
	input  wire logic signed [31:0]  right_val,
	input  wire logic                right_vld,
	output logic signed [31:0]       val,
	output logic                     vld,
	output logic                     ins_here,
	output logic                     match
);
	import slid_pkg::*;

	logic signed [31:0] val_q;
	logic               vld_q;
	logic               del_here;

	// Sorted order makes both flags monotone along the chain
	assign ins_here = !vld_q || (val_q > ctl.key);
	assign del_here = !vld_q || (val_q >= ctl.key);
	assign match    = vld_q && (val_q == ctl.key);
	assign val      = val_q;
	assign vld      = vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			case (ctl.op)
				CELL_INSERT: begin
					if (ins_here) begin
						vld_q <= left_ins ? left_vld : 1'b1;
					end
				end
				CELL_DELETE: begin
					if (del_here) begin
						vld_q <= right_vld;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ctl.op)
			CELL_INSERT: begin
				// shift right from the insert point, drop the key into the gap
				if (ins_here) begin
					val_q <= left_ins ? left_val : ctl.key;
				end
			end
			CELL_DELETE: begin
				// close the gap from the right
				if (del_here) begin
					val_q <= right_val;
				end
			end
			CELL_ROTATE: begin
				// rotate among valid cells: the last valid one takes the head
				if (vld_q) begin
					val_q <= right_vld ? right_val : head_val;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

// File: design/sorted_list_insert_delete_unit.sv
// Top level of the sorted list unit: command control and the chain of cells
//
//  channel   handshake            payload
//  request   start / busy         request (command, value)
//  result    strobe, no stall     result (status, count, position, entry, valid, last)
//
// A request is taken on the edge where start is high and busy is low. The chain
// updates in that cycle; then one result per stored entry follows on back-to-back
// cycles (one result when empty).
// The emit run rotates the chain once through its valid cells.
// Reset clears the valid bits and count; the store reads empty at once.
// Results cannot be stalled; busy stays high until the last one is shown.
`timescale 1ns / 1ps
`default_nettype none

module sorted_list_insert_delete_unit #(
	parameter int CAPACITY = 16
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire logic           start,
	output logic                busy,
	input  wire slid_pkg::req_t request,
	output logic                strobe,
	output slid_pkg::rsp_t      result
);
	import slid_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = $clog2(CAPACITY);

	state_t          state_q, state_next;
	logic [CW-1:0]   count_q;
	logic [IW-1:0]   idx_q;
	status_t         status_q;
	cell_ctl_t       ctl;

	logic signed [31:0] cell_val [CAPACITY];
	logic signed [31:0] left_val [CAPACITY];
	logic signed [31:0] right_val [CAPACITY];
	logic [CAPACITY-1:0] cell_vld, left_vld, right_vld, cell_ins, left_ins, cell_match;

	logic accept, full, found, is_last;

	assign accept = start && (state_q == S_IDLE);
	assign full   = (count_q == CW'(CAPACITY));
	assign found  = |cell_match;
	assign is_last = (count_q == '0) || ((CW'(idx_q) + CW'(1)) == count_q);

	always_comb begin
		ctl.key = request.value;
		ctl.op  = CELL_HOLD;
		if (accept) begin
			if (request.command == CMD_INSERT) begin
				ctl.op = full ? CELL_HOLD : CELL_INSERT;
			end else begin
				ctl.op = found ? CELL_DELETE : CELL_HOLD;
			end
		end else if (state_q == S_EMIT) begin
			ctl.op = CELL_ROTATE;
		end
	end

	genvar gi;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
			if (gi == 0) begin : g_head
				assign left_val[gi] = '0;
				assign left_vld[gi] = 1'b0;
				assign left_ins[gi] = 1'b0;
			end else begin : g_mid
				assign left_val[gi] = cell_val[gi-1];
				assign left_vld[gi] = cell_vld[gi-1];
				assign left_ins[gi] = cell_ins[gi-1];
			end
			if (gi == CAPACITY - 1) begin : g_tail
				assign right_val[gi] = '0;
				assign right_vld[gi] = 1'b0;
			end else begin : g_body
				assign right_val[gi] = cell_val[gi+1];
				assign right_vld[gi] = cell_vld[gi+1];
			end
			slid_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctl       (ctl),
				.head_val  (cell_val[0]),
				.left_val  (left_val[gi]),
				.left_vld  (left_vld[gi]),
				.left_ins  (left_ins[gi]),
				.right_val (right_val[gi]),
				.right_vld (right_vld[gi]),
				.val       (cell_val[gi]),
				.vld       (cell_vld[gi]),
				.ins_here  (cell_ins[gi]),
				.match     (cell_match[gi])
			);
		end
	endgenerate

	// Next state
	always_comb begin
		state_next = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_next = S_EMIT;
				end
			end
			S_EMIT: begin
				if (is_last) begin
					state_next = S_IDLE;
				end
			end
			default: begin
				state_next = S_IDLE;
			end
		endcase
	end

	// Outputs
	always_comb begin
		busy   = 1'b0;
		strobe = 1'b0;
		case (state_q)
			S_EMIT: begin
				busy   = 1'b1;
				strobe = 1'b1;
			end
			default: begin
			end
		endcase
		result.status      = status_q;
		result.entry_count = 5'(count_q);
		result.position    = 4'(idx_q);
		result.entry_value = cell_vld[0] ? cell_val[0] : '0;
		result.entry_valid = cell_vld[0];
		result.last        = is_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			idx_q    <= '0;
			status_q <= STAT_DONE;
		end else begin
			state_q <= state_next;
			if (accept) begin
				idx_q <= '0;
				if (request.command == CMD_INSERT) begin
					if (full) begin
						status_q <= STAT_FULL;
					end else begin
						status_q <= STAT_DONE;
						count_q  <= count_q + CW'(1);
					end
				end else begin
					if (found) begin
						status_q <= STAT_DONE;
						count_q  <= count_q - CW'(1);
					end else begin
						status_q <= STAT_NOT_FOUND;
					end
				end
			end else if (state_q == S_EMIT) begin
				idx_q <= idx_q + IW'(1);
			end
		end
	end

endmodule

`default_nettype wire

// File: design/slid_checker.sv
// Port-level checks for the sorted list unit and their bind
`timescale 1ns / 1ps
`default_nettype none

`include "sorted_list_insert_delete_unit_macros.svh"

module slid_checker (
	input wire                 clk,
	input wire                 arst_n,
	input wire logic           start,
	input wire logic           busy,
	input wire slid_pkg::rsp_t result,
	input wire logic           strobe
);
	import slid_pkg::*;

	// an accepted request always starts a result run
	`SLID_ASSERT(a_accept_runs, start && !busy |=> strobe && result.position == 4'd0, "request gave no run")

	// a run does not break off before its last result
	`SLID_ASSERT(a_run_continues, strobe && !result.last |=> strobe, "result run broken off")

	// ranks climb by one through the run
	`SLID_ASSERT(a_rank_step, strobe && !result.last |=> result.position == 4'($past(result.position) + 4'd1), "rank skipped")

	// the run ends after its last result
	`SLID_ASSERT(a_run_ends, strobe && result.last |=> !strobe, "result after last")

	// results only appear while the unit is busy
	`SLID_ASSERT_ALWAYS(a_strobe_busy, strobe |-> busy, "result while not busy")

endmodule

bind sorted_list_insert_delete_unit slid_checker u_slid_checker (.*);

`default_nettype wire
